### sv/stack_bytecode_executor_top_assert.svh
// Assertion macros for the stack bytecode executor.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef STACK_BYTECODE_EXECUTOR_TOP_ASSERT_SVH
`define STACK_BYTECODE_EXECUTOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbe assertion failed");

// antecedent implies consequent in the following cycle
`define SBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbe assertion failed");

`endif

### sv/sbe_pkg.sv
// Package for the stack bytecode executor: opcodes, codes, types and decoder.
// No dependencies; used by sbe_alu, stack_bytecode_executor_top and the testbench.
`timescale 1ns / 1ps

package sbe_pkg;

    localparam logic [7:0] OP_NOP           = 8'h00;
    localparam logic [7:0] OP_ICONST_M1     = 8'h02;
    localparam logic [7:0] OP_ICONST_0      = 8'h03;
    localparam logic [7:0] OP_ICONST_5      = 8'h08;
    localparam logic [7:0] OP_BIPUSH        = 8'h10;
    localparam logic [7:0] OP_SIPUSH        = 8'h11;
    localparam logic [7:0] OP_ILOAD         = 8'h15;
    localparam logic [7:0] OP_ALOAD         = 8'h19;
    localparam logic [7:0] OP_ILOAD_0       = 8'h1a;
    localparam logic [7:0] OP_ILOAD_3       = 8'h1d;
    localparam logic [7:0] OP_ALOAD_0       = 8'h2a;
    localparam logic [7:0] OP_ALOAD_3       = 8'h2d;
    localparam logic [7:0] OP_ISTORE        = 8'h36;
    localparam logic [7:0] OP_ASTORE        = 8'h3a;
    localparam logic [7:0] OP_ISTORE_0      = 8'h3b;
    localparam logic [7:0] OP_ISTORE_3      = 8'h3e;
    localparam logic [7:0] OP_ASTORE_0      = 8'h4b;
    localparam logic [7:0] OP_ASTORE_3      = 8'h4e;
    localparam logic [7:0] OP_DUP           = 8'h59;
    localparam logic [7:0] OP_IADD          = 8'h60;
    localparam logic [7:0] OP_ISUB          = 8'h64;
    localparam logic [7:0] OP_IMUL          = 8'h68;
    localparam logic [7:0] OP_IDIV          = 8'h6c;
    localparam logic [7:0] OP_IREM          = 8'h70;
    localparam logic [7:0] OP_INEG          = 8'h74;
    localparam logic [7:0] OP_ISHL          = 8'h78;
    localparam logic [7:0] OP_ISHR          = 8'h7a;
    localparam logic [7:0] OP_IUSHR         = 8'h7c;
    localparam logic [7:0] OP_IAND          = 8'h7e;
    localparam logic [7:0] OP_IOR           = 8'h80;
    localparam logic [7:0] OP_IXOR          = 8'h82;
    localparam logic [7:0] OP_IINC          = 8'h84;
    localparam logic [7:0] OP_IFEQ          = 8'h99;
    localparam logic [7:0] OP_IFLE          = 8'h9e;
    localparam logic [7:0] OP_IF_ICMPEQ     = 8'h9f;
    localparam logic [7:0] OP_IF_ICMPLE     = 8'ha4;
    localparam logic [7:0] OP_GOTO          = 8'ha7;
    localparam logic [7:0] OP_IRETURN       = 8'hac;
    localparam logic [7:0] OP_ARETURN       = 8'hb0;
    localparam logic [7:0] OP_RETURN        = 8'hb1;
    localparam logic [7:0] OP_GETSTATIC     = 8'hb2;
    localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hb6;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_DIVZERO   = 3'd3;
    localparam logic [2:0] ERR_BADOP     = 3'd4;

    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_VOID  = 2'd1;
    localparam logic [1:0] RK_VALUE = 2'd2;

    // branch condition, relative to the first opcode of each branch group
    localparam logic [2:0] CC_EQ = 3'd0;
    localparam logic [2:0] CC_NE = 3'd1;
    localparam logic [2:0] CC_LT = 3'd2;
    localparam logic [2:0] CC_GE = 3'd3;
    localparam logic [2:0] CC_GT = 3'd4;
    localparam logic [2:0] CC_LE = 3'd5;

    typedef enum logic [4:0] {
        OC_NOP, OC_CONST, OC_BIPUSH, OC_SIPUSH, OC_LOAD, OC_STORE, OC_DUP,
        OC_ARITH, OC_DIV, OC_NEG, OC_IINC, OC_IF1, OC_IF2, OC_GOTO,
        OC_RETV, OC_RET, OC_PRINT, OC_BAD
    } op_class_t;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_AND, ALU_OR, ALU_XOR,
        ALU_SHL, ALU_SHR, ALU_USHR, ALU_DIV, ALU_REM
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_RDB, S_RDA, S_EXEC, S_WAIT, S_WB
    } state_t;

    typedef struct packed {
        logic      done;
        logic      eq;
        logic      lt;
        logic      gt;
    } alu_stat_t;

    typedef struct packed {
        op_class_t  cls;
        alu_op_t    aop;
        logic [1:0] pops;
        logic [1:0] pushes;
        logic [1:0] len;
        logic       idx_op;
    } dec_t;

    function automatic dec_t decode(input logic [7:0] op);
        dec_t d;
        d.cls    = OC_BAD;
        d.aop    = ALU_ADD;
        d.pops   = 2'd0;
        d.pushes = 2'd0;
        d.len    = 2'd1;
        d.idx_op = 1'b0;
        unique case (op) inside
            OP_NOP:
                d.cls = OC_NOP;
            OP_GETSTATIC:
            begin
                d.cls = OC_NOP;
                d.len = 2'd3;
            end
            [OP_ICONST_M1:OP_ICONST_5]:
            begin
                d.cls = OC_CONST;
                d.pushes = 2'd1;
            end
            OP_BIPUSH:
            begin
                d.cls = OC_BIPUSH;
                d.pushes = 2'd1;
                d.len = 2'd2;
            end
            OP_SIPUSH:
            begin
                d.cls = OC_SIPUSH;
                d.pushes = 2'd1;
                d.len = 2'd3;
            end
            OP_ILOAD, OP_ALOAD:
            begin
                d.cls = OC_LOAD;
                d.pushes = 2'd1;
                d.len = 2'd2;
            end
            [OP_ILOAD_0:OP_ILOAD_3], [OP_ALOAD_0:OP_ALOAD_3]:
            begin
                d.cls = OC_LOAD; d.pushes = 2'd1; d.idx_op = 1'b1;
            end
            OP_ISTORE, OP_ASTORE:
            begin
                d.cls = OC_STORE;
                d.pops = 2'd1;
                d.len = 2'd2;
            end
            [OP_ISTORE_0:OP_ISTORE_3], [OP_ASTORE_0:OP_ASTORE_3]:
            begin
                d.cls = OC_STORE; d.pops = 2'd1; d.idx_op = 1'b1;
            end
            OP_DUP:
            begin
                d.cls = OC_DUP;
                d.pops = 2'd1;
                d.pushes = 2'd2;
            end
            OP_IADD, OP_ISUB, OP_IMUL, OP_ISHL, OP_ISHR, OP_IUSHR, OP_IAND, OP_IOR, OP_IXOR:
            begin
                d.cls = OC_ARITH; d.pops = 2'd2; d.pushes = 2'd1;
            end
            OP_IDIV, OP_IREM:
            begin
                d.cls = OC_DIV;
                d.pops = 2'd2;
                d.pushes = 2'd1;
            end
            OP_INEG:
            begin
                d.cls = OC_NEG;
                d.pops = 2'd1;
                d.pushes = 2'd1;
            end
            OP_IINC:
            begin
                d.cls = OC_IINC;
                d.len = 2'd3;
            end
            [OP_IFEQ:OP_IFLE]:
            begin
                d.cls = OC_IF1;
                d.pops = 2'd1;
                d.len = 2'd3;
            end
            [OP_IF_ICMPEQ:OP_IF_ICMPLE]:
            begin
                d.cls = OC_IF2;
                d.pops = 2'd2;
                d.len = 2'd3;
            end
            OP_GOTO:
            begin
                d.cls = OC_GOTO;
                d.len = 2'd3;
            end
            OP_IRETURN, OP_ARETURN:
            begin
                d.cls = OC_RETV;
                d.pops = 2'd1;
            end
            OP_RETURN:
                d.cls = OC_RET;
            OP_INVOKEVIRTUAL:
            begin
                d.cls = OC_PRINT;
                d.pops = 2'd1;
                d.len = 2'd3;
            end
            default:
                d.cls = OC_BAD;
        endcase
        unique case (op)
            OP_ISUB:  d.aop = ALU_SUB;
            OP_INEG:  d.aop = ALU_SUB;
            OP_IMUL:  d.aop = ALU_MUL;
            OP_IDIV:  d.aop = ALU_DIV;
            OP_IREM:  d.aop = ALU_REM;
            OP_ISHL:  d.aop = ALU_SHL;
            OP_ISHR:  d.aop = ALU_SHR;
            OP_IUSHR: d.aop = ALU_USHR;
            OP_IAND:  d.aop = ALU_AND;
            OP_IOR:   d.aop = ALU_OR;
            OP_IXOR:  d.aop = ALU_XOR;
            default:  d.aop = ALU_ADD;
        endcase
        return d;
    endfunction

endpackage

### sv/sbe_alu.sv
// Shared arithmetic unit: add/sub/logic/shift/multiply ready the cycle after start,
// signed divide and remainder by a one-bit-per-cycle restoring loop. Uses sbe_pkg.
`timescale 1ns / 1ps

module sbe_alu
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sbe_pkg::alu_op_t  op,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output logic [31:0]       result,
    output sbe_pkg::alu_stat_t stat
);

    logic [31:0] res_reg;
    logic        done_reg;
    logic        busy_reg;
    logic        fix_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] mb_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        is_rem_reg;

    logic [31:0] quick;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] rem_next;
    logic [31:0] quo_next;
    logic        is_div;

    always_comb
    begin
        case (op)
            sbe_pkg::ALU_SUB:  quick = a - b;
            sbe_pkg::ALU_MUL:  quick = a * b;
            sbe_pkg::ALU_AND:  quick = a & b;
            sbe_pkg::ALU_OR:   quick = a | b;
            sbe_pkg::ALU_XOR:  quick = a ^ b;
            sbe_pkg::ALU_SHL:  quick = a << b[4:0];
            sbe_pkg::ALU_SHR:  quick = $unsigned($signed(a) >>> b[4:0]);
            sbe_pkg::ALU_USHR: quick = a >> b[4:0];
            default:           quick = a + b;
        endcase
        is_div   = (op == sbe_pkg::ALU_DIV) || (op == sbe_pkg::ALU_REM);
        trial    = {rem_reg, quo_reg[31]};
        diff     = trial - {1'b0, mb_reg};
        rem_next = diff[32] ? trial[31:0] : diff[31:0];
        quo_next = {quo_reg[30:0], ~diff[32]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && is_div)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (start)
            begin
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && is_div)
        begin
            rem_reg    <= 32'd0;
            quo_reg    <= a[31] ? (32'd0 - a) : a;
            mb_reg     <= b[31] ? (32'd0 - b) : b;
            neg_q_reg  <= a[31] ^ b[31];
            neg_r_reg  <= a[31];
            is_rem_reg <= (op == sbe_pkg::ALU_REM);
        end
        else if (start)
        begin
            res_reg <= quick;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        else if (fix_reg)
        begin
            if (is_rem_reg)
                res_reg <= neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
            else
                res_reg <= neg_q_reg ? (32'd0 - quo_reg) : quo_reg;
        end
    end

    assign result    = res_reg;
    assign stat.done = done_reg;
    assign stat.eq   = (a == b);
    assign stat.lt   = ($signed(a) < $signed(b));
    assign stat.gt   = ($signed(a) > $signed(b));

endmodule

### sv/stack_bytecode_executor_top.sv
// Top level of the stack bytecode executor: sequencer, operand stack, locals.
// Depends on sbe_pkg, sbe_alu and stack_bytecode_executor_top_assert.svh.
//
// Use: one bytecode per input item on s_* (tdata: opcode, operand_hi, operand_lo).
// One result item per input on m_*: tdata carries pc_offset, print_value,
// return_value, error_code; tuser carries print_valid, return_kind.
// Sequence: check (errors go straight to write-back), stack reads for opcodes
// that pop, execute, a wait on the shared unit for unit operations (idiv/irem
// run 32 divide steps plus setup and sign fix), then write-back. The block
// takes one item at a time; s_tready is high only while the sequencer waits
// for an item.
// The result sits in an output register; a new item is accepted while it
// waits, and the sequencer holds in its write-back step, with no state
// changed, until the receiver has taken the previous result.
// Reset: stack empty, all locals read as zero (valid bit per local), no
// result pending. No clearing pass.
`timescale 1ns / 1ps
`include "stack_bytecode_executor_top_assert.svh"

module stack_bytecode_executor_top
#(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[7:0], operand_hi[15:8], operand_lo[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // pc_offset[15:0], print_value[47:16],
                                   // return_value[79:48], error_code[82:80], zero pad
    output logic [2:0]  m_tuser    // print_valid[0], return_kind[2:1]
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(LOCAL_COUNT);

    sbe_pkg::state_t state_reg, state_next;
    logic [7:0]    op_reg, hi_reg, lo_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   a_reg, b_reg;
    logic [2:0]    err_reg, err_next;
    logic          taken_reg, taken_next;

    logic          m_tvalid_reg;
    logic [15:0]   pc_o_reg;
    logic          pv_o_reg;
    logic [31:0]   pval_o_reg;
    logic [1:0]    rk_o_reg;
    logic [31:0]   rval_o_reg;
    logic [2:0]    err_o_reg;

    logic [31:0]   stk_mem [STACK_DEPTH];
    logic [31:0]   stk_q;
    logic [SW-1:0] stk_raddr, stk_waddr;
    logic          stk_we;
    logic [31:0]   stk_wdata;

    logic [31:0]      lv_mem [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] lv_valid_reg;
    logic [31:0]      lv_q;
    logic             lv_vq;
    logic             lv_inr_reg;
    logic             lv_re, lv_we;
    logic [31:0]      lv_wdata;
    logic [31:0]      lv_val;

    sbe_pkg::dec_t    dec;
    logic [7:0]       ld_d, st_d, lidx8, if_d;
    logic             lidx_inr;
    logic [LW-1:0]    lidx;
    logic [CW-1:0]    base;
    logic [CW:0]      after;
    logic             adv;
    logic [31:0]      r;
    logic [2:0]       cc;
    logic             cond;
    logic             need_alu;
    logic             is_ret;

    logic               alu_start;
    sbe_pkg::alu_op_t   alu_op;
    logic [31:0]        alu_a, alu_b, alu_res;
    sbe_pkg::alu_stat_t alu_stat;

    sbe_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .stat   (alu_stat)
    );

    always_comb
    begin
        dec      = sbe_pkg::decode(op_reg);
        ld_d     = op_reg - sbe_pkg::OP_ILOAD_0;
        st_d     = op_reg - sbe_pkg::OP_ISTORE_0;
        if (!dec.idx_op)
            lidx8 = hi_reg;
        else if (dec.cls == sbe_pkg::OC_LOAD)
            lidx8 = {6'd0, ld_d[1:0]};
        else
            lidx8 = {6'd0, st_d[1:0]};
        lidx_inr = ({1'b0, lidx8} < 9'(LOCAL_COUNT));
        lidx     = lidx8[LW-1:0];
        lv_val   = (lv_vq && lv_inr_reg) ? lv_q : 32'd0;
        base     = cnt_reg - CW'(dec.pops);
        after    = {1'b0, cnt_reg} - (CW+1)'(dec.pops) + (CW+1)'(dec.pushes);
        adv      = !m_tvalid_reg || m_tready;
        is_ret   = (dec.cls == sbe_pkg::OC_RETV) || (dec.cls == sbe_pkg::OC_RET);
        need_alu = (dec.cls == sbe_pkg::OC_ARITH) || (dec.cls == sbe_pkg::OC_DIV) ||
                   (dec.cls == sbe_pkg::OC_NEG) || (dec.cls == sbe_pkg::OC_IINC);
        if_d     = (dec.cls == sbe_pkg::OC_IF1) ? (op_reg - sbe_pkg::OP_IFEQ)
                                                : (op_reg - sbe_pkg::OP_IF_ICMPEQ);
        cc       = if_d[2:0];
    end

    // shared unit operands
    always_comb
    begin
        alu_op = dec.aop;
        alu_a  = a_reg;
        alu_b  = b_reg;
        case (dec.cls)
            sbe_pkg::OC_NEG:
            begin
                alu_a = 32'd0;
            end
            sbe_pkg::OC_IINC:
            begin
                alu_a = lv_val;
                alu_b = {{24{lo_reg[7]}}, lo_reg};
            end
            sbe_pkg::OC_IF1:
            begin
                alu_a = b_reg;
                alu_b = 32'd0;
            end
            default:
            begin
                alu_a = a_reg;
                alu_b = b_reg;
            end
        endcase
        case (cc)
            sbe_pkg::CC_EQ: cond = alu_stat.eq;
            sbe_pkg::CC_NE: cond = !alu_stat.eq;
            sbe_pkg::CC_LT: cond = alu_stat.lt;
            sbe_pkg::CC_GE: cond = !alu_stat.lt;
            sbe_pkg::CC_GT: cond = alu_stat.gt;
            sbe_pkg::CC_LE: cond = !alu_stat.gt;
            default:        cond = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        taken_next = taken_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        alu_start  = 1'b0;
        lv_re      = 1'b0;
        stk_raddr  = SW'(cnt_reg - CW'(1));
        stk_we     = 1'b0;
        stk_waddr  = SW'(base);
        stk_wdata  = r;
        lv_we      = 1'b0;
        lv_wdata   = (dec.cls == sbe_pkg::OC_IINC) ? alu_res : b_reg;
        unique case (state_reg)
            sbe_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = sbe_pkg::S_CHECK;
                    err_next   = sbe_pkg::ERR_OK;
                    taken_next = 1'b0;
                end
            end
            sbe_pkg::S_CHECK:
            begin
                lv_re = 1'b1;
                if (dec.cls == sbe_pkg::OC_BAD)
                begin
                    err_next   = sbe_pkg::ERR_BADOP;
                    state_next = sbe_pkg::S_WB;
                end
                else if (CW'(dec.pops) > cnt_reg)
                begin
                    err_next   = sbe_pkg::ERR_UNDERFLOW;
                    state_next = sbe_pkg::S_WB;
                end
                else if (after > (CW+1)'(STACK_DEPTH))
                begin
                    err_next   = sbe_pkg::ERR_OVERFLOW;
                    state_next = sbe_pkg::S_WB;
                end
                else if (dec.pops != 2'd0)
                    state_next = sbe_pkg::S_RDB;
                else
                    state_next = sbe_pkg::S_EXEC;
            end
            sbe_pkg::S_RDB:
            begin
                stk_raddr  = SW'(cnt_reg - CW'(2));
                state_next = (dec.pops == 2'd2) ? sbe_pkg::S_RDA : sbe_pkg::S_EXEC;
            end
            sbe_pkg::S_RDA:
            begin
                state_next = sbe_pkg::S_EXEC;
            end
            sbe_pkg::S_EXEC:
            begin
                if ((dec.cls == sbe_pkg::OC_DIV) && (b_reg == 32'd0))
                begin
                    err_next   = sbe_pkg::ERR_DIVZERO;
                    state_next = sbe_pkg::S_WB;
                end
                else if (need_alu)
                begin
                    alu_start  = 1'b1;
                    state_next = sbe_pkg::S_WAIT;
                end
                else
                begin
                    taken_next = (dec.cls == sbe_pkg::OC_GOTO) ||
                                 (((dec.cls == sbe_pkg::OC_IF1) ||
                                   (dec.cls == sbe_pkg::OC_IF2)) && cond);
                    state_next = sbe_pkg::S_WB;
                end
            end
            sbe_pkg::S_WAIT:
            begin
                if (alu_stat.done)
                    state_next = sbe_pkg::S_WB;
            end
            sbe_pkg::S_WB:
            begin
                if (adv)
                begin
                    state_next = sbe_pkg::S_IDLE;
                    if (err_reg == sbe_pkg::ERR_OK)
                    begin
                        stk_we = (dec.pushes != 2'd0);
                        if (dec.cls == sbe_pkg::OC_DUP)
                            stk_waddr = SW'(cnt_reg);
                        lv_we = ((dec.cls == sbe_pkg::OC_STORE) ||
                                 (dec.cls == sbe_pkg::OC_IINC)) && lidx_inr;
                        cnt_next = is_ret ? CW'(0) : CW'(after);
                    end
                end
            end
            default:
            begin
                state_next = sbe_pkg::S_IDLE;
            end
        endcase
    end

    // value pushed
    always_comb
    begin
        case (dec.cls)
            sbe_pkg::OC_CONST:  r = {24'd0, op_reg} - {24'd0, sbe_pkg::OP_ICONST_0};
            sbe_pkg::OC_BIPUSH: r = {{24{hi_reg[7]}}, hi_reg};
            sbe_pkg::OC_SIPUSH: r = {{16{hi_reg[7]}}, hi_reg, lo_reg};
            sbe_pkg::OC_LOAD:   r = lv_val;
            sbe_pkg::OC_DUP:    r = b_reg;
            default:            r = alu_res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sbe_pkg::S_IDLE;
            cnt_reg      <= '0;
            err_reg      <= sbe_pkg::ERR_OK;
            taken_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            lv_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            taken_reg <= taken_next;
            if (lv_we)
                lv_valid_reg[lidx] <= 1'b1;
            if ((state_reg == sbe_pkg::S_WB) && adv)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg <= s_tdata[7:0];
            hi_reg <= s_tdata[15:8];
            lo_reg <= s_tdata[23:16];
        end
        if (state_reg == sbe_pkg::S_RDB)
            b_reg <= stk_q;
        if (state_reg == sbe_pkg::S_RDA)
            a_reg <= stk_q;
        if ((state_reg == sbe_pkg::S_WB) && adv)
        begin
            if (err_reg != sbe_pkg::ERR_OK)
            begin
                pc_o_reg   <= 16'd0;
                pv_o_reg   <= 1'b0;
                pval_o_reg <= 32'd0;
                rk_o_reg   <= sbe_pkg::RK_NONE;
                rval_o_reg <= 32'd0;
            end
            else
            begin
                pc_o_reg   <= taken_reg ? {hi_reg, lo_reg} : {14'd0, dec.len};
                pv_o_reg   <= (dec.cls == sbe_pkg::OC_PRINT);
                pval_o_reg <= (dec.cls == sbe_pkg::OC_PRINT) ? b_reg : 32'd0;
                rk_o_reg   <= (dec.cls == sbe_pkg::OC_RETV) ? sbe_pkg::RK_VALUE :
                              (dec.cls == sbe_pkg::OC_RET)  ? sbe_pkg::RK_VOID :
                                                              sbe_pkg::RK_NONE;
                rval_o_reg <= (dec.cls == sbe_pkg::OC_RETV) ? b_reg : 32'd0;
            end
            err_o_reg <= err_reg;
        end
    end

    // operand stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_q <= stk_mem[stk_raddr];
    end

    // local variable memory
    always_ff @(posedge clk)
    begin
        if (lv_we)
            lv_mem[lidx] <= lv_wdata;
        if (lv_re)
        begin
            lv_q       <= lv_mem[lidx];
            lv_vq      <= lv_valid_reg[lidx];
            lv_inr_reg <= lidx_inr;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, err_o_reg, rval_o_reg, pval_o_reg, pc_o_reg};
    assign m_tuser  = {rk_o_reg, pv_o_reg};

    `SBE_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(STACK_DEPTH))
    `SBE_ASSERT_NXT(a_err_keeps_cnt, clk, rst_n,
        (state_reg == sbe_pkg::S_WB) && adv && (err_reg != sbe_pkg::ERR_OK), $stable(cnt_reg))
    `SBE_ASSERT_NXT(a_ret_empties, clk, rst_n,
        (state_reg == sbe_pkg::S_WB) && adv && (err_reg == sbe_pkg::ERR_OK) && is_ret,
        cnt_reg == CW'(0))

endmodule

### verif/stack_bytecode_executor_top_tb.sv
// Testbench for stack_bytecode_executor_top: directed and random bytecode items,
// with a local predictor of the stack, locals and results. Depends on sbe_pkg and stack_bytecode_executor_top.
`timescale 1ns / 1ps

module stack_bytecode_executor_top_tb;

    localparam int DEPTH  = 64;
    localparam int NLOCAL = 256;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] op;
    } bc_item_t;

    typedef struct packed {
        logic [15:0] pc_off;
        logic        pvalid;
        logic [31:0] pvalue;
        logic [1:0]  rkind;
        logic [31:0] rvalue;
        logic [2:0]  err;
    } exec_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;

    bc_item_t    pending_q[$];
    exec_res_t   expected_q[$];
    logic [31:0] pstack[DEPTH] = '{default: 32'd0};
    logic [31:0] plocals[NLOCAL] = '{default: 32'd0};
    int          pdepth = 0;
    int          fail_count = 0;
    int          sent_count = 0;
    int          offered_count = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          hold_cycles = 0;
    bit          calm = 1'b0;
    bit          drain_pause = 1'b0;
    bit          stall_phase = 1'b0;
    bit          stall_done = 1'b0;

    stack_bytecode_executor_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] local_rd(logic [7:0] idx);
        return (int'(idx) < NLOCAL) ? plocals[idx] : 32'd0;
    endfunction

    function automatic void local_wr(logic [7:0] idx, logic [31:0] v);
        if (int'(idx) < NLOCAL)
            plocals[idx] = v;
    endfunction

    function automatic bit cond_met(logic [7:0] d, logic [31:0] x, logic [31:0] y);
        case (d[2:0])
            sbe_pkg::CC_EQ: return x == y;
            sbe_pkg::CC_NE: return x != y;
            sbe_pkg::CC_LT: return $signed(x) < $signed(y);
            sbe_pkg::CC_GE: return $signed(x) >= $signed(y);
            sbe_pkg::CC_GT: return $signed(x) > $signed(y);
            default:        return $signed(x) <= $signed(y);
        endcase
    endfunction

    function automatic logic [31:0] sdivrem(logic [31:0] a, logic [31:0] b, bit rem);
        logic [31:0] ma, mb, q, r;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (rem)
            return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic exec_res_t execute_bytecode(bc_item_t it);
        exec_res_t res;
        int pops, pushes, len, base;
        bit ok, taken;
        logic [31:0] a, b, r, br;
        logic [7:0] op;
        op = it.op;
        res = '0;
        pops = 0; pushes = 0; len = 1; ok = 1'b1; taken = 1'b0;
        a = '0; b = '0; r = '0;
        br = {{16{it.hi[7]}}, it.hi, it.lo};
        case (op) inside
            sbe_pkg::OP_NOP, sbe_pkg::OP_RETURN:
                len = 1;
            [sbe_pkg::OP_ICONST_M1:sbe_pkg::OP_ICONST_5]:
                pushes = 1;
            sbe_pkg::OP_BIPUSH, sbe_pkg::OP_ILOAD, sbe_pkg::OP_ALOAD:
            begin
                pushes = 1;
                len = 2;
            end
            sbe_pkg::OP_SIPUSH:
            begin
                pushes = 1;
                len = 3;
            end
            [sbe_pkg::OP_ILOAD_0:sbe_pkg::OP_ILOAD_3], [sbe_pkg::OP_ALOAD_0:sbe_pkg::OP_ALOAD_3]:
                pushes = 1;
            sbe_pkg::OP_ISTORE, sbe_pkg::OP_ASTORE:
            begin
                pops = 1;
                len = 2;
            end
            [sbe_pkg::OP_ISTORE_0:sbe_pkg::OP_ISTORE_3],
            [sbe_pkg::OP_ASTORE_0:sbe_pkg::OP_ASTORE_3]:
                pops = 1;
            sbe_pkg::OP_DUP:
            begin
                pops = 1;
                pushes = 2;
            end
            sbe_pkg::OP_IADD, sbe_pkg::OP_ISUB, sbe_pkg::OP_IMUL, sbe_pkg::OP_IDIV,
            sbe_pkg::OP_IREM, sbe_pkg::OP_ISHL, sbe_pkg::OP_ISHR, sbe_pkg::OP_IUSHR,
            sbe_pkg::OP_IAND, sbe_pkg::OP_IOR, sbe_pkg::OP_IXOR:
            begin
                pops = 2;
                pushes = 1;
            end
            sbe_pkg::OP_INEG:
            begin
                pops = 1;
                pushes = 1;
            end
            sbe_pkg::OP_IINC, sbe_pkg::OP_GOTO, sbe_pkg::OP_GETSTATIC:
                len = 3;
            [sbe_pkg::OP_IFEQ:sbe_pkg::OP_IFLE], sbe_pkg::OP_INVOKEVIRTUAL:
            begin
                pops = 1;
                len = 3;
            end
            [sbe_pkg::OP_IF_ICMPEQ:sbe_pkg::OP_IF_ICMPLE]:
            begin
                pops = 2;
                len = 3;
            end
            sbe_pkg::OP_IRETURN, sbe_pkg::OP_ARETURN:
                pops = 1;
            default:
                ok = 1'b0;
        endcase

        if (!ok)
        begin
            res.err = sbe_pkg::ERR_BADOP;
            return res;
        end
        if (pops > pdepth)
        begin
            res.err = sbe_pkg::ERR_UNDERFLOW;
            return res;
        end
        if (pdepth - pops + pushes > DEPTH)
        begin
            res.err = sbe_pkg::ERR_OVERFLOW;
            return res;
        end
        if (pops >= 1) b = pstack[pdepth - 1];
        if (pops >= 2) a = pstack[pdepth - 2];
        if ((op == sbe_pkg::OP_IDIV || op == sbe_pkg::OP_IREM) && b == 32'd0)
        begin
            res.err = sbe_pkg::ERR_DIVZERO;
            return res;
        end

        base = pdepth - pops;
        res.pc_off = len[15:0];
        case (op) inside
            [sbe_pkg::OP_ICONST_M1:sbe_pkg::OP_ICONST_5]:
                r = 32'(op) - 32'(sbe_pkg::OP_ICONST_0);
            sbe_pkg::OP_BIPUSH:  r = {{24{it.hi[7]}}, it.hi};
            sbe_pkg::OP_SIPUSH:  r = br;
            sbe_pkg::OP_ILOAD, sbe_pkg::OP_ALOAD:
                r = local_rd(it.hi);
            [sbe_pkg::OP_ILOAD_0:sbe_pkg::OP_ILOAD_3]:
                r = local_rd(op - sbe_pkg::OP_ILOAD_0);
            [sbe_pkg::OP_ALOAD_0:sbe_pkg::OP_ALOAD_3]:
                r = local_rd(op - sbe_pkg::OP_ALOAD_0);
            sbe_pkg::OP_ISTORE, sbe_pkg::OP_ASTORE:
                local_wr(it.hi, b);
            [sbe_pkg::OP_ISTORE_0:sbe_pkg::OP_ISTORE_3]:
                local_wr(op - sbe_pkg::OP_ISTORE_0, b);
            [sbe_pkg::OP_ASTORE_0:sbe_pkg::OP_ASTORE_3]:
                local_wr(op - sbe_pkg::OP_ASTORE_0, b);
            sbe_pkg::OP_DUP:
            begin
                pstack[base] = b;
                base++;
                r = b;
            end
            sbe_pkg::OP_IADD:  r = a + b;
            sbe_pkg::OP_ISUB:  r = a - b;
            sbe_pkg::OP_IMUL:  r = a * b;
            sbe_pkg::OP_IDIV:  r = sdivrem(a, b, 1'b0);
            sbe_pkg::OP_IREM:  r = sdivrem(a, b, 1'b1);
            sbe_pkg::OP_INEG:  r = -b;
            sbe_pkg::OP_ISHL:  r = a << b[4:0];
            sbe_pkg::OP_ISHR:  r = $unsigned($signed(a) >>> b[4:0]);
            sbe_pkg::OP_IUSHR: r = a >> b[4:0];
            sbe_pkg::OP_IAND:  r = a & b;
            sbe_pkg::OP_IOR:   r = a | b;
            sbe_pkg::OP_IXOR:  r = a ^ b;
            sbe_pkg::OP_IINC:
                local_wr(it.hi, local_rd(it.hi) + {{24{it.lo[7]}}, it.lo});
            [sbe_pkg::OP_IFEQ:sbe_pkg::OP_IFLE]:
                taken = cond_met(op - sbe_pkg::OP_IFEQ, b, 32'd0);
            [sbe_pkg::OP_IF_ICMPEQ:sbe_pkg::OP_IF_ICMPLE]:
                taken = cond_met(op - sbe_pkg::OP_IF_ICMPEQ, a, b);
            sbe_pkg::OP_GOTO:
                taken = 1'b1;
            sbe_pkg::OP_IRETURN, sbe_pkg::OP_ARETURN:
            begin
                res.rkind = sbe_pkg::RK_VALUE;
                res.rvalue = b;
            end
            sbe_pkg::OP_RETURN:
                res.rkind = sbe_pkg::RK_VOID;
            sbe_pkg::OP_INVOKEVIRTUAL:
            begin
                res.pvalid = 1'b1;
                res.pvalue = b;
            end
            default:
                r = '0;
        endcase

        if (pushes >= 1)
        begin
            pstack[base] = r;
            base++;
        end
        pdepth = base;
        if (res.rkind != sbe_pkg::RK_NONE) pdepth = 0;
        if (taken) res.pc_off = br[15:0];
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(logic [7:0] op, logic [7:0] hi, logic [7:0] lo);
        bc_item_t it;
        it.op = op; it.hi = hi; it.lo = lo;
        pending_q.push_back(it);
    endtask

    // pushes a full 32-bit value: sipush high half, shift by 16, sipush low half,
    // mask it to 16 bits, or
    task automatic push_word(logic [31:0] v);
        add_item(sbe_pkg::OP_SIPUSH, v[31:24], v[23:16]);
        add_item(sbe_pkg::OP_BIPUSH, 8'd16, 8'd0);
        add_item(sbe_pkg::OP_ISHL, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_SIPUSH, v[15:8], v[7:0]);
        add_item(sbe_pkg::OP_ICONST_M1, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_BIPUSH, 8'd16, 8'd0);
        add_item(sbe_pkg::OP_IUSHR, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_IAND, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_IOR, 8'd0, 8'd0);
    endtask

    task automatic random_program();
        logic [7:0] ops[] = '{sbe_pkg::OP_IADD, sbe_pkg::OP_ISUB, sbe_pkg::OP_IMUL,
                              sbe_pkg::OP_IDIV, sbe_pkg::OP_IREM, sbe_pkg::OP_ISHL,
                              sbe_pkg::OP_ISHR, sbe_pkg::OP_IUSHR, sbe_pkg::OP_IAND,
                              sbe_pkg::OP_IOR, sbe_pkg::OP_IXOR};
        logic [7:0] op;
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
        begin
            push_word(rand_word());
            push_word(rand_word());
            if ($urandom_range(0, 3) == 0)
                op = 8'(sbe_pkg::OP_IF_ICMPEQ + $urandom_range(0, 5));
            else
                op = ops[$urandom_range(0, 10)];
            add_item(op, 8'($urandom), 8'($urandom));
            if (op < sbe_pkg::OP_IF_ICMPEQ)
            begin
                if ($urandom_range(0, 1) == 1)
                    add_item(sbe_pkg::OP_INVOKEVIRTUAL, 8'($urandom), 8'($urandom));
                else
                    add_item(sbe_pkg::OP_ISTORE, 8'($urandom), 8'($urandom));
            end
        end
        else if (k < 8)
        begin
            if ($urandom_range(0, 1) == 1)
                add_item(sbe_pkg::OP_BIPUSH, 8'($urandom), 8'($urandom));
            else
                add_item(sbe_pkg::OP_SIPUSH, 8'($urandom), 8'($urandom));
            case ($urandom_range(0, 7))
                0: add_item(8'(sbe_pkg::OP_IFEQ + $urandom_range(0, 5)),
                            8'($urandom), 8'($urandom));
                1: add_item(sbe_pkg::OP_INEG, 8'd0, 8'd0);
                2: add_item(sbe_pkg::OP_DUP, 8'd0, 8'd0);
                3: add_item(8'(sbe_pkg::OP_ISTORE_0 + $urandom_range(0, 3)), 8'd0, 8'd0);
                4: add_item(sbe_pkg::OP_ASTORE, 8'($urandom), 8'd0);
                5: add_item(sbe_pkg::OP_IINC, 8'($urandom), 8'($urandom));
                6: add_item(8'(sbe_pkg::OP_ILOAD + 4 * $urandom_range(0, 1)),
                            8'($urandom), 8'd0);
                default: add_item(8'(sbe_pkg::OP_ALOAD_0 + $urandom_range(0, 3)), 8'd0, 8'd0);
            endcase
        end
        else if (k == 8)
            add_item(8'($urandom), 8'($urandom), 8'($urandom));
        else if ($urandom_range(0, 1) == 1)
            add_item(sbe_pkg::OP_IRETURN, 8'd0, 8'd0);
        else
            add_item(sbe_pkg::OP_RETURN, 8'd0, 8'd0);
    endtask

    // driver: at most one assignment per signal per falling edge; the item on
    // the bus has been taken once the monitor has counted every offered item
    always @(negedge clk)
    begin
        bit took;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || (sent_count == offered_count))
        begin
            took = s_tvalid;
            if (src_gap > 0 || drain_pause || pending_q.size() == 0 ||
                (took && !calm && $urandom_range(0, 7) == 0))
            begin
                if (src_gap > 0)
                    src_gap = src_gap - 1;
                else if (took && !drain_pause && !calm)
                    src_gap = $urandom_range(0, 13);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata       <= pending_q.pop_front();
                s_tvalid      <= 1'b1;
                offered_count = offered_count + 1;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (stall_phase && !stall_done)
            begin
                hold_cycles = 300;
                stall_done  = 1'b1;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap = sink_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (!calm && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 14);
                m_tready <= 1'b1;
            end
        end
    end

    // prediction on accepted input, checking on accepted output
    always @(posedge clk)
    begin
        exec_res_t got, exp;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_q.push_back(execute_bytecode(bc_item_t'(s_tdata)));
            sent_count = sent_count + 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pc_off = m_tdata[15:0];
            got.pvalue = m_tdata[47:16];
            got.rvalue = m_tdata[79:48];
            got.err    = m_tdata[82:80];
            got.pvalid = m_tuser[0];
            got.rkind  = m_tuser[2:1];
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with none expected: %h", $time, got);
                fail_count++;
            end
            else
            begin
                exp = expected_q.pop_front();
                if (got !== exp)
                begin
                    $display({"%0t: mismatch pc_off %h/%h pvalid %b/%b pval %h/%h ",
                              "rkind %0d/%0d rval %h/%h err %0d/%0d (exp/act)"},
                             $time, exp.pc_off, got.pc_off, exp.pvalid, got.pvalid,
                             exp.pvalue, got.pvalue, exp.rkind, got.rkind,
                             exp.rvalue, got.rvalue, exp.err, got.err);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("stack_bytecode_executor_top test failed");
        $finish;
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: underflow, bad op, constants, extremes, div corners, overflow
        add_item(sbe_pkg::OP_IADD, 8'd0, 8'd0);
        add_item(8'hFF, 8'hFF, 8'hFF);
        add_item(sbe_pkg::OP_ICONST_M1, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_ICONST_5, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_SIPUSH, 8'h80, 8'h00);
        add_item(sbe_pkg::OP_BIPUSH, 8'h10, 8'd0);
        add_item(sbe_pkg::OP_ISHL, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_ICONST_M1, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_IDIV, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_DUP, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_ICONST_0, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_IREM, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_ICONST_M1, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_IREM, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_ISTORE, 8'hFF, 8'd0);
        add_item(sbe_pkg::OP_IINC, 8'hFF, 8'h80);
        add_item(sbe_pkg::OP_ILOAD, 8'hFF, 8'd0);
        add_item(sbe_pkg::OP_INVOKEVIRTUAL, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_GETSTATIC, 8'd0, 8'd0);
        add_item(sbe_pkg::OP_GOTO, 8'h80, 8'h00);
        add_item(sbe_pkg::OP_IRETURN, 8'd0, 8'd0);
        for (i = 0; i < 65; i++) add_item(8'(sbe_pkg::OP_ICONST_0 + (i % 6)), 8'd0, 8'd0);
        add_item(sbe_pkg::OP_RETURN, 8'd0, 8'd0);
        while (pending_q.size() > 0 || expected_q.size() > 0 || s_tvalid) @(posedge clk);

        // long receiver stall while the sender keeps offering
        for (i = 0; i < 12; i++) add_item(sbe_pkg::OP_BIPUSH, 8'(i), 8'd0);
        stall_phase = 1'b1;
        while (pending_q.size() > 0 || expected_q.size() > 0 || s_tvalid) @(posedge clk);

        while (sent_count < 1950)
        begin
            if (sent_count > 1700) calm = 1'b1;
            random_program();
            if (pending_q.size() > 20)
            begin
                if (!calm && $urandom_range(0, 30) == 0)
                begin
                    drain_pause = 1'b1;
                    while (expected_q.size() > 0 || s_tvalid) @(posedge clk);
                    drain_pause = 1'b0;
                end
                while (pending_q.size() > 20) @(posedge clk);
            end
        end
        while (pending_q.size() > 0 || expected_q.size() > 0 || s_tvalid) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("stack_bytecode_executor_top test passed");
        else
            $display("stack_bytecode_executor_top test failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/sbe_pkg.sv
sv/sbe_alu.sv
sv/stack_bytecode_executor_top.sv
verif/stack_bytecode_executor_top_tb.sv
